@@ hw/rtl/e2ep2_pkg.sv @@
// types, constants and the crc-8 update shared by the profile 2 receive check
// no dependencies
package e2ep2_pkg;

    localparam int LEN_W     = 9;
    localparam int ID_W      = 64;
    localparam int CTR_W     = 4;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;

    typedef logic [7:0]          byte_t;
    typedef logic [CTR_W-1:0]    ctr_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK             = 3'd0;
    localparam status_t ST_OK_SOME_LOST   = 3'd1;
    localparam status_t ST_WRONG_CRC      = 3'd2;
    localparam status_t ST_WRONG_SEQUENCE = 3'd3;
    localparam status_t ST_REPEATED       = 3'd4;
    localparam status_t ST_INITIAL        = 3'd5;
    localparam status_t ST_NO_NEW_DATA    = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_MSG_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ID_LOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ID_HIGH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELTA_INIT = 2'd3;

    localparam byte_t CRC_POLY  = 8'h2F;
    localparam byte_t CRC_INIT  = 8'hFF;
    localparam byte_t CRC_XOROUT = 8'hFF;
    localparam ctr_t  DELTA_MAX = 4'd15;

    function automatic byte_t crc8_upd(input byte_t crc, input byte_t data);
        byte_t c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/e2e_profile2_checker.sv @@
// e2e profile 2 receive check, top level
// depends on e2ep2_pkg
//
// Checks end-to-end protected messages fed one byte per request: byte 0 is
// the received crc, the low nibble of byte 1 is the sequence counter that
// picks one of 16 data id bytes from the configuration. A crc-8 (poly 0x2F,
// init/xorout 0xFF) runs over bytes 1..L-1 and the data id. One result per
// message end or per no-new-data request (tuser high), none for other bytes.
// One request is taken every cycle unless a result waits on m_tready; each
// goes through an input register and one pass of crc/classify logic into the
// result register. Configuration is to be written through cfg_we/cfg_index/
// cfg_wdata while the block is idle; the user must see to this, the block does not enforce it.
module e2e_profile2_checker
    import e2ep2_pkg::*;
#(
    parameter int MAX_MSG_BYTES = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // data_byte
    input  logic                 s_tuser,   // req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // status[2:0], lost_count[6:3], zero
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ID_W-1:0]      cfg_wdata
);

    localparam int POS_W = (MAX_MSG_BYTES > 2) ? $clog2(MAX_MSG_BYTES) : 1;

    // configuration
    logic [LEN_W-1:0] msg_bytes_reg;
    logic [ID_W-1:0]  id_low_reg;
    logic [ID_W-1:0]  id_high_reg;
    ctr_t             delta_init_reg;

    // input register
    logic  in_valid_reg;
    logic  in_type_reg;
    byte_t in_byte_reg;

    // check state
    logic             awaiting_first_reg, awaiting_first_next;
    ctr_t             allowed_delta_reg, allowed_delta_next;
    ctr_t             last_ctr_reg, last_ctr_next;
    ctr_t             lost_reg, lost_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    byte_t            crc_reg, crc_next;
    byte_t            rx_crc_reg, rx_crc_next;
    ctr_t             rx_ctr_reg, rx_ctr_next;

    // result register
    logic    m_valid_reg, m_valid_next;
    status_t m_status_reg, m_status_next;
    ctr_t    m_lost_reg, m_lost_next;

    logic             [LEN_W-1:0] eff_len;
    logic             [LEN_W-1:0] last_pos;
    logic             msg_end;
    logic             produces;
    logic             advance;
    logic             proc;
    ctr_t             ctr_use;
    ctr_t             delta_raised;
    ctr_t             seq_delta;
    byte_t            crc_upd;
    byte_t            crc_calc;
    byte_t            data_id;
    logic [2*ID_W-1:0] id_all;

    always_comb begin
        if (msg_bytes_reg < LEN_W'(2)) begin
            eff_len = LEN_W'(2);
        end else if (msg_bytes_reg > LEN_W'(MAX_MSG_BYTES)) begin
            eff_len = LEN_W'(MAX_MSG_BYTES);
        end else begin
            eff_len = msg_bytes_reg;
        end
    end

    assign last_pos = eff_len - LEN_W'(1);
    assign msg_end  = (pos_reg != '0) && (LEN_W'(pos_reg) >= last_pos);
    assign produces = in_type_reg || msg_end;
    assign advance  = !in_valid_reg || !produces || !m_valid_reg || m_tready;
    assign s_tready = advance;
    assign proc     = in_valid_reg && advance;

    assign ctr_use      = (pos_reg == POS_W'(1)) ? in_byte_reg[CTR_W-1:0] : rx_ctr_reg;
    assign id_all       = {id_high_reg, id_low_reg};
    assign data_id      = id_all[{ctr_use, 3'b000} +: 8];
    assign crc_upd      = crc8_upd(crc_reg, in_byte_reg);
    assign crc_calc     = crc8_upd(crc_upd, data_id) ^ CRC_XOROUT;
    assign delta_raised = (allowed_delta_reg < DELTA_MAX) ? allowed_delta_reg + ctr_t'(1)
                                                          : allowed_delta_reg;
    assign seq_delta    = ctr_use - last_ctr_reg;

    always_comb begin
        awaiting_first_next = awaiting_first_reg;
        allowed_delta_next  = allowed_delta_reg;
        last_ctr_next       = last_ctr_reg;
        lost_next           = lost_reg;
        pos_next            = pos_reg;
        crc_next            = crc_reg;
        rx_crc_next         = rx_crc_reg;
        rx_ctr_next         = rx_ctr_reg;
        m_status_next       = m_status_reg;
        m_lost_next         = m_lost_reg;
        m_valid_next        = m_valid_reg && !m_tready;
        if (proc) begin
            if (in_type_reg) begin
                allowed_delta_next = delta_raised;
                m_valid_next       = 1'b1;
                m_status_next      = ST_NO_NEW_DATA;
                m_lost_next        = lost_reg;
            end else if (pos_reg == '0) begin
                rx_crc_next = in_byte_reg;
                crc_next    = CRC_INIT;
                pos_next    = POS_W'(1);
            end else begin
                rx_ctr_next = ctr_use;
                if (!msg_end) begin
                    pos_next = pos_reg + POS_W'(1);
                    crc_next = crc_upd;
                end else begin
                    pos_next           = '0;
                    crc_next           = CRC_INIT;
                    allowed_delta_next = delta_raised;
                    m_valid_next       = 1'b1;
                    if (crc_calc != rx_crc_reg) begin
                        m_status_next = ST_WRONG_CRC;
                    end else if (awaiting_first_reg) begin
                        awaiting_first_next = 1'b0;
                        allowed_delta_next  = delta_init_reg;
                        last_ctr_next       = ctr_use;
                        m_status_next       = ST_INITIAL;
                    end else if (seq_delta == '0) begin
                        m_status_next = ST_REPEATED;
                    end else if (seq_delta > delta_raised) begin
                        m_status_next = ST_WRONG_SEQUENCE;
                    end else begin
                        allowed_delta_next = delta_init_reg;
                        last_ctr_next      = ctr_use;
                        lost_next          = seq_delta - ctr_t'(1);
                        m_status_next      = (seq_delta == ctr_t'(1)) ? ST_OK
                                                                      : ST_OK_SOME_LOST;
                    end
                    m_lost_next = lost_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msg_bytes_reg      <= LEN_W'(8);
            id_low_reg         <= '0;
            id_high_reg        <= '0;
            delta_init_reg     <= ctr_t'(1);
            in_valid_reg       <= 1'b0;
            awaiting_first_reg <= 1'b1;
            allowed_delta_reg  <= '0;
            last_ctr_reg       <= '0;
            lost_reg           <= '0;
            pos_reg            <= '0;
            crc_reg            <= CRC_INIT;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MSG_BYTES:  msg_bytes_reg  <= cfg_wdata[LEN_W-1:0];
                    REG_ID_LOW:     id_low_reg     <= cfg_wdata;
                    REG_ID_HIGH:    id_high_reg    <= cfg_wdata;
                    REG_DELTA_INIT: delta_init_reg <= cfg_wdata[CTR_W-1:0];
                    default: ;
                endcase
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            awaiting_first_reg <= awaiting_first_next;
            allowed_delta_reg  <= allowed_delta_next;
            last_ctr_reg       <= last_ctr_next;
            lost_reg           <= lost_next;
            pos_reg            <= pos_next;
            crc_reg            <= crc_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_type_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        rx_crc_reg   <= rx_crc_next;
        rx_ctr_reg   <= rx_ctr_next;
        m_status_reg <= m_status_next;
        m_lost_reg   <= m_lost_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_lost_reg, m_status_reg};

endmodule
